// ----- rtl/gtc_pkg.sv -----
// ----------------------------------------------------------------------------
// gtc_pkg
// Shared types, constants and commands for the greenhouse tick controller.
// ----------------------------------------------------------------------------
package gtc_pkg;

    localparam int WINDOW_LEN_DEF = 50;
    localparam int SAMPLE_BITS    = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_DOOR_HOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_OK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_INT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_DUR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLIND_CLOSE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLIND_OPEN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_PER   = 3'd7;

    localparam logic [1:0] BLIND_NONE  = 2'd0;
    localparam logic [1:0] BLIND_CLOSE = 2'd1;
    localparam logic [1:0] BLIND_OPEN  = 2'd2;

    localparam logic [1:0] COLOR_OFF   = 2'd0;
    localparam logic [1:0] COLOR_GREEN = 2'd1;
    localparam logic [1:0] COLOR_BLUE  = 2'd2;

    typedef struct packed {
        logic [31:0] tick_ms;
        logic        grant_level;
        logic        emergency;
        logic [11:0] water_reading;
        logic [11:0] light_reading;
    } gtc_in_t;

    typedef struct packed {
        logic [6:0]  door_angle;
        logic        door_moved;
        logic        buzzer_on;
        logic        pump_on;
        logic [5:0]  hose_deg;
        logic [1:0]  lamp_count;
        logic [1:0]  blind_move;
        logic [1:0]  status_color;
        logic [11:0] light_average;
        logic        water_shortage;
        logic        later_skipped;
    } gtc_out_t;

    typedef struct packed {
        logic [15:0] door_hold_ms;
        logic [11:0] water_low_level;
        logic [11:0] water_ok_level;
        logic [19:0] water_interval_ms;
        logic [15:0] water_duration_ms;
        logic [11:0] blind_close_level;
        logic [11:0] blind_open_level;
        logic [15:0] light_period_ms;
    } gtc_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CTRL,
        ST_SAMPLE,
        ST_DIV,
        ST_FINISH
    } gtc_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic ctrl;       // door, water and hose update
        logic sample;     // window read-modify-write (if sample due)
        logic div_start;  // start average division
        logic div_step;   // one quotient bit
        logic finish;     // blind and status update, build result
    } gtc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic skip_light; // emergency or sample not due
        logic div_done;
    } gtc_sts_t;

    function automatic logic [1:0] lamps_for(input logic [11:0] avg);
        if (avg < 12'd500)       return 2'd3;
        else if (avg < 12'd800)  return 2'd2;
        else if (avg < 12'd1200) return 2'd1;
        else                     return 2'd0;
    endfunction

endpackage

// ----- rtl/gtc_ctrl.sv -----
// ----------------------------------------------------------------------------
// gtc_ctrl
// Pass sequencer: steps one control pass through the datapath.
// ----------------------------------------------------------------------------
module gtc_ctrl
    import gtc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  gtc_sts_t sts,
    output gtc_cmd_t cmd
);

    gtc_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    // result register may be refilled when empty or being taken this cycle
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_CTRL;
            ST_CTRL:   state_next = ST_SAMPLE;
            ST_SAMPLE: state_next = sts.skip_light ? ST_FINISH : ST_DIV;
            ST_DIV:    if (sts.div_done) state_next = ST_FINISH;
            ST_FINISH: if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CTRL:   cmd.ctrl = 1'b1;
            ST_SAMPLE:
            begin
                cmd.sample    = !sts.skip_light;
                cmd.div_start = !sts.skip_light;
            end
            ST_DIV:    cmd.div_step = !sts.div_done;
            ST_FINISH: cmd.finish = slot_free;
            default:   cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.ctrl, cmd.sample, cmd.div_step, cmd.finish}))
        else $error("more than one datapath command");
    a_out_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.finish))
        else $error("result shown without finish step");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> slot_free)
        else $error("result overwritten while waiting");

endmodule

// ----- rtl/gtc_datapath.sv -----
// ----------------------------------------------------------------------------
// gtc_datapath
// Controller state, light window memory, serial divider and result register.
// ----------------------------------------------------------------------------
module gtc_datapath
    import gtc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  gtc_cfg_t cfg,
    input  gtc_in_t  in_item,
    input  gtc_cmd_t cmd,
    output gtc_sts_t sts,
    output gtc_out_t out_item
);

    localparam int SLOT_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W  = $clog2(WINDOW_LEN + 1);
    localparam int TOTAL_W = SAMPLE_BITS + FILL_W;
    localparam int CNT_W   = $clog2(TOTAL_W + 1);

    gtc_in_t      in_reg;
    logic [6:0]   door_pos_reg;
    logic [31:0]  door_step_time_reg, open_deadline_reg;
    logic         grant_prev_reg, moved_reg;
    logic         shortage_reg, tone_state_reg, buzz_reg;
    logic [31:0]  tone_time_reg;
    logic         watering_reg;
    logic [31:0]  water_start_reg, water_end_reg;
    logic [5:0]   hose_pos_reg;
    logic         hose_up_reg;
    logic [31:0]  hose_time_reg;
    logic         active_reg;

    logic [SAMPLE_BITS-1:0] window_mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0]  window_vld_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [11:0]            avg_reg;
    logic [31:0]            sample_time_reg;
    logic [SAMPLE_BITS-1:0] old_rd_reg;

    logic [TOTAL_W-1:0]     quo_reg;
    logic [FILL_W:0]        rem_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   div_busy_reg;

    logic         blind_closed_reg, blink_on_reg, blink_time_vld;
    logic [31:0]  blink_time_reg;
    logic         active_prev_reg;
    logic [1:0]   led_reg;
    gtc_out_t     out_reg;

    logic [31:0]  tick;
    assign tick = in_reg.tick_ms;
    assign blink_time_vld = 1'b1;

    // read the slot that the sample will replace while the pass runs
    always_ff @(posedge clk)
    begin
        old_rd_reg <= window_mem[slot_reg];
        if (cmd.sample)
        begin
            window_mem[slot_reg] <= in_reg.light_reading[SAMPLE_BITS-1:0];
        end
    end

    logic [31:0] deadline_now;
    logic [6:0]  target;
    logic        act_door;
    always_comb
    begin
        deadline_now = open_deadline_reg;
        if (in_reg.grant_level && !grant_prev_reg)
        begin
            deadline_now = tick + 32'(cfg.door_hold_ms);
        end
        act_door = 1'b0;
        if (in_reg.emergency)
        begin
            target = 7'd90;
        end
        else if (tick < deadline_now)
        begin
            target   = 7'd90;
            act_door = 1'b1;
        end
        else
        begin
            target = 7'd0;
        end
    end

    logic sample_due;
    assign sample_due = (tick - sample_time_reg) >= 32'(cfg.light_period_ms);
    assign sts.skip_light = in_reg.emergency || !sample_due;
    assign sts.div_done   = div_busy_reg && (cnt_reg == '0);

    logic [FILL_W:0] rem_sh;
    assign rem_sh = {rem_reg[FILL_W-1:0], quo_reg[TOTAL_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            door_pos_reg <= '0; door_step_time_reg <= '0; open_deadline_reg <= '0;
            grant_prev_reg <= 1'b0; moved_reg <= 1'b0;
            shortage_reg <= 1'b0; tone_state_reg <= 1'b0; buzz_reg <= 1'b0;
            tone_time_reg <= '0; watering_reg <= 1'b0;
            water_start_reg <= '0; water_end_reg <= '0;
            hose_pos_reg <= 6'd25; hose_up_reg <= 1'b1; hose_time_reg <= '0;
            active_reg <= 1'b0;
            window_vld_reg <= '0; slot_reg <= '0; total_reg <= '0; fill_reg <= '0;
            avg_reg <= '0; sample_time_reg <= '0;
            quo_reg <= '0; rem_reg <= '0; cnt_reg <= '0; div_busy_reg <= 1'b0;
            blind_closed_reg <= 1'b0; blink_on_reg <= 1'b0; blink_time_reg <= '0;
            active_prev_reg <= 1'b0; led_reg <= COLOR_OFF;
            out_reg <= '0;
            in_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                in_reg <= in_item;
            end

            if (cmd.ctrl)
            begin
                logic step_door;
                logic act;
                step_door = (door_pos_reg != target) &&
                            ((tick - door_step_time_reg) >= 32'd10);
                act = act_door || (door_pos_reg != target);
                open_deadline_reg <= deadline_now;
                grant_prev_reg    <= in_reg.grant_level;
                moved_reg         <= step_door;
                if (step_door)
                begin
                    if (door_pos_reg < target)
                    begin
                        door_pos_reg <= (door_pos_reg + 7'd10 > target) ? target
                                        : door_pos_reg + 7'd10;
                    end
                    else
                    begin
                        door_pos_reg <= (door_pos_reg >= target + 7'd10)
                                        ? door_pos_reg - 7'd10 : target;
                    end
                    door_step_time_reg <= tick;
                end

                if (!in_reg.emergency)
                begin
                    logic sf;
                    logic wf;
                    sf = shortage_reg;
                    if (in_reg.water_reading < cfg.water_low_level) sf = 1'b1;
                    else if (in_reg.water_reading > cfg.water_ok_level) sf = 1'b0;
                    shortage_reg <= sf;
                    if (sf)
                    begin
                        if ((tick - tone_time_reg) >= 32'd500)
                        begin
                            tone_state_reg <= !tone_state_reg;
                            buzz_reg       <= !tone_state_reg;
                            tone_time_reg  <= tick;
                        end
                        watering_reg <= 1'b0;
                    end
                    else
                    begin
                        logic [31:0] ws;
                        logic [5:0]  hp;
                        buzz_reg <= 1'b0;
                        wf = watering_reg;
                        ws = water_start_reg;
                        if (!wf && (tick - water_end_reg) >= 32'(cfg.water_interval_ms))
                        begin
                            wf = 1'b1;
                            ws = tick;
                        end
                        water_start_reg <= ws;
                        if (wf)
                        begin
                            act = 1'b1;
                            if ((tick - hose_time_reg) >= 32'd90)
                            begin
                                if (hose_up_reg) hp = hose_pos_reg + 6'd5;
                                else hp = (hose_pos_reg >= 6'd5) ? hose_pos_reg - 6'd5 : 6'd0;
                                if (hp > 6'd50) hp = 6'd50;
                                if (hp >= 6'd50 || hp == 6'd0) hose_up_reg <= !hose_up_reg;
                                hose_pos_reg  <= hp;
                                hose_time_reg <= tick;
                            end
                            if ((tick - ws) >= 32'(cfg.water_duration_ms))
                            begin
                                wf = 1'b0;
                                water_end_reg <= tick;
                            end
                        end
                        watering_reg <= wf;
                    end
                end
                active_reg <= act;
            end

            if (cmd.sample)
            begin
                logic [TOTAL_W-1:0] t;
                logic [SAMPLE_BITS-1:0] old;
                logic [FILL_W-1:0] f;
                old = window_vld_reg[slot_reg] ? old_rd_reg : '0;
                t = total_reg - TOTAL_W'(old) + TOTAL_W'(in_reg.light_reading[SAMPLE_BITS-1:0]);
                f = (fill_reg < FILL_W'(WINDOW_LEN)) ? fill_reg + 1'b1 : fill_reg;
                total_reg <= t;
                fill_reg  <= f;
                window_vld_reg[slot_reg] <= 1'b1;
                slot_reg <= (slot_reg == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_reg + 1'b1;
                sample_time_reg <= tick;
                quo_reg      <= t;
                rem_reg      <= '0;
                cnt_reg      <= CNT_W'(TOTAL_W);
                div_busy_reg <= 1'b1;
            end

            // restoring division, one quotient bit per cycle
            if (cmd.div_step)
            begin
                if (rem_sh >= {1'b0, fill_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, fill_reg};
                    quo_reg <= {quo_reg[TOTAL_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[TOTAL_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
            else if (sts.div_done)
            begin
                avg_reg      <= quo_reg[11:0];
                div_busy_reg <= 1'b0;
            end

            if (cmd.finish)
            begin
                gtc_out_t o;
                logic     want, act;
                logic [1:0] led;
                o = out_reg;
                o.door_angle = door_pos_reg;
                o.door_moved = moved_reg;
                o.later_skipped = in_reg.emergency;
                o.blind_move = BLIND_NONE;
                // during emergency the held color shows
                o.status_color = led_reg;
                if (!in_reg.emergency)
                begin
                    act  = active_reg;
                    led  = led_reg;
                    want = blind_closed_reg;
                    if (avg_reg > cfg.blind_close_level) want = 1'b1;
                    else if (avg_reg < cfg.blind_open_level) want = 1'b0;
                    if (want != blind_closed_reg)
                    begin
                        act = 1'b1;
                        led = COLOR_BLUE;
                        o.blind_move = want ? BLIND_CLOSE : BLIND_OPEN;
                        blind_closed_reg <= want;
                    end
                    if (act)
                    begin
                        if (!active_prev_reg)
                        begin
                            blink_on_reg   <= 1'b1;
                            blink_time_reg <= tick;
                            led = COLOR_BLUE;
                        end
                        else if (blink_time_vld && (tick - blink_time_reg) >= 32'd500)
                        begin
                            blink_on_reg   <= !blink_on_reg;
                            led = !blink_on_reg ? COLOR_BLUE : COLOR_OFF;
                            blink_time_reg <= tick;
                        end
                        active_prev_reg <= 1'b1;
                    end
                    else
                    begin
                        led = COLOR_GREEN;
                        active_prev_reg <= 1'b0;
                        blink_on_reg    <= 1'b0;
                    end
                    led_reg <= led;
                    o.status_color = led;
                end
                o.buzzer_on      = buzz_reg;
                o.pump_on        = watering_reg;
                o.hose_deg       = hose_pos_reg;
                o.lamp_count     = lamps_for(avg_reg);
                o.light_average  = avg_reg;
                o.water_shortage = shortage_reg;
                out_reg <= o;
            end
        end
    end

    assign out_item = out_reg;

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> div_busy_reg && (cnt_reg == CNT_W'(TOTAL_W)))
        else $error("divider not started");
    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> fill_reg != '0)
        else $error("division by empty window");
    a_door_range: assert property (@(posedge clk) disable iff (!rst_n)
        door_pos_reg <= 7'd90)
        else $error("door angle out of range");

endmodule

// ----- rtl/greenhouse_tick_controller_top.sv -----
// ----------------------------------------------------------------------------
// greenhouse_tick_controller_top
// One control pass in, one drive command transaction out.
// ----------------------------------------------------------------------------
// Each accepted input transaction is one control pass and yields exactly one
// result transaction. When no light sample is due (or during emergency) the
// pass moves from the control and sample steps straight to the finish step,
// which registers the result. When a sample enters the window the
// one-bit-per-cycle divider that forms the window average runs between the
// sample and finish steps and yields the quotient of the TOTAL_W-bit total
// (TOTAL_W = SAMPLE_BITS + clog2(WINDOW_LEN+1), 18 at the defaults).
// One pass is worked at a time. A finished result waits in its own
// register, so the next pass is accepted and runs while it is held; only the
// final step of that next pass stalls until the waiting result has been
// taken. Configuration writes land at once and must only be issued while no
// pass is in flight.
module greenhouse_tick_controller_top
    import gtc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gtc_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gtc_out_t              out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    gtc_cfg_t cfg_reg;
    gtc_cmd_t cmd;
    gtc_sts_t sts;

    // configuration registers, reset to their documented defaults
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.door_hold_ms      <= 16'd10000;
            cfg_reg.water_low_level   <= 12'd1500;
            cfg_reg.water_ok_level    <= 12'd1800;
            cfg_reg.water_interval_ms <= 20'd30000;
            cfg_reg.water_duration_ms <= 16'd1000;
            cfg_reg.blind_close_level <= 12'd1700;
            cfg_reg.blind_open_level  <= 12'd1200;
            cfg_reg.light_period_ms   <= 16'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DOOR_HOLD:   cfg_reg.door_hold_ms      <= cfg_data[15:0];
                REG_WATER_LOW:   cfg_reg.water_low_level   <= cfg_data[11:0];
                REG_WATER_OK:    cfg_reg.water_ok_level    <= cfg_data[11:0];
                REG_WATER_INT:   cfg_reg.water_interval_ms <= cfg_data[19:0];
                REG_WATER_DUR:   cfg_reg.water_duration_ms <= cfg_data[15:0];
                REG_BLIND_CLOSE: cfg_reg.blind_close_level <= cfg_data[11:0];
                REG_BLIND_OPEN:  cfg_reg.blind_open_level  <= cfg_data[11:0];
                REG_LIGHT_PER:   cfg_reg.light_period_ms   <= cfg_data[15:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    gtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gtc_datapath #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_item  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_item (out_data)
    );

endmodule
